// ----- hdl/wfcd_pkg.sv -----
// Shared types, codes and scaling tables for the wheel force command decoder.
`default_nettype none

package wfcd_pkg;

  // Result kinds
  localparam logic [1:0] KIND_SWITCH = 2'd0;
  localparam logic [1:0] KIND_FORCE  = 2'd1;
  localparam logic [1:0] KIND_GAIN   = 2'd2;
  localparam logic [1:0] KIND_CENTER = 2'd3;

  // Fixed command codes
  localparam logic [7:0] CODE_RESET_ALL = 8'h00;
  localparam logic [7:0] CODE_CENTER_A  = 8'h3F;
  localparam logic [7:0] CODE_CENTER_B  = 8'hAF;
  localparam logic [7:0] CODE_ALL_OFF   = 8'h7F;
  localparam logic [7:0] CODE_FORCE_OFF = 8'hBD;
  localparam logic [7:0] CODE_FULL_ON   = 8'hFF;

  // Code classes, taken from code bits 4..1
  localparam logic [7:0] CLASS_MASK       = 8'h1E;
  localparam logic [7:0] CLASS_ROLL_RIGHT = 8'd24;
  localparam logic [7:0] CLASS_ROLL_LEFT  = 8'h14;
  localparam logic [7:0] CLASS_CLUTCH     = 8'h1A;
  localparam logic [7:0] CLASS_CENTER     = 8'h02;

  localparam logic [16:0] FULL_LEVEL = 17'd65535;
  localparam logic [16:0] ZERO_LEVEL = 17'd0;

  // Command sequence chosen for one poll
  typedef enum logic [2:0] {
    OP_NONE              = 3'd0,
    OP_FORCE_GAIN_CENTER = 3'd1,
    OP_CENTER_FORCE_GAIN = 3'd2,
    OP_ALL_OFF           = 3'd3,
    OP_FORCE_GAIN        = 3'd4,
    OP_ROLL_RIGHT        = 3'd5,
    OP_ROLL_LEFT         = 3'd6,
    OP_CLUTCH            = 3'd7
  } op_t;

  // One classified poll as queued between front and back
  typedef struct packed {
    logic [7:0] switch_bits;
    op_t        op;
    logic [2:0] step_sel;
  } entry_t;

  // Queue status seen by the front and the back
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // One command beat
  typedef struct packed {
    logic [1:0]  kind;
    logic [16:0] level;
  } beat_t;

  // Force magnitude v*32767/100 for each step
  function automatic logic [14:0] force_table(logic [2:0] sel);
    logic [14:0] f;
    case (sel)
      3'd0:    f = 15'd32767;
      3'd1:    f = 15'd28179;
      3'd2:    f = 15'd23592;
      3'd3:    f = 15'd19004;
      3'd4:    f = 15'd14089;
      3'd5:    f = 15'd9502;
      3'd6:    f = 15'd4915;
      default: f = 15'd0;
    endcase
    return f;
  endfunction

  // Clutch gain 65535*v/100 for each step
  function automatic logic [15:0] gain_table(logic [2:0] sel);
    logic [15:0] g;
    case (sel)
      3'd0:    g = 16'd65535;
      3'd1:    g = 16'd56360;
      3'd2:    g = 16'd47185;
      3'd3:    g = 16'd38010;
      3'd4:    g = 16'd28180;
      3'd5:    g = 16'd19005;
      3'd6:    g = 16'd9830;
      default: g = 16'd0;
    endcase
    return g;
  endfunction

  // Number of command beats that follow the switch beat
  function automatic logic [1:0] op_len(op_t op);
    logic [1:0] n;
    unique case (op)
      OP_NONE:                                          n = 2'd0;
      OP_FORCE_GAIN_CENTER, OP_CENTER_FORCE_GAIN, OP_ALL_OFF: n = 2'd3;
      OP_FORCE_GAIN:                                    n = 2'd2;
      OP_ROLL_RIGHT, OP_ROLL_LEFT, OP_CLUTCH:           n = 2'd1;
      default:                                          n = 2'd0;
    endcase
    return n;
  endfunction

  // Command beat number idx of a sequence
  function automatic beat_t cmd_at(op_t op, logic [1:0] idx, logic [2:0] sel);
    beat_t b;
    b.kind  = KIND_FORCE;
    b.level = ZERO_LEVEL;
    unique case (op)
      OP_FORCE_GAIN_CENTER: begin
        case (idx)
          2'd0:    b = '{KIND_FORCE, ZERO_LEVEL};
          2'd1:    b = '{KIND_GAIN, FULL_LEVEL};
          default: b = '{KIND_CENTER, FULL_LEVEL};
        endcase
      end
      OP_CENTER_FORCE_GAIN: begin
        case (idx)
          2'd0:    b = '{KIND_CENTER, FULL_LEVEL};
          2'd1:    b = '{KIND_FORCE, ZERO_LEVEL};
          default: b = '{KIND_GAIN, FULL_LEVEL};
        endcase
      end
      OP_ALL_OFF: begin
        case (idx)
          2'd0:    b = '{KIND_FORCE, ZERO_LEVEL};
          2'd1:    b = '{KIND_GAIN, ZERO_LEVEL};
          default: b = '{KIND_CENTER, ZERO_LEVEL};
        endcase
      end
      OP_FORCE_GAIN: begin
        case (idx)
          2'd0:    b = '{KIND_FORCE, ZERO_LEVEL};
          default: b = '{KIND_GAIN, FULL_LEVEL};
        endcase
      end
      OP_ROLL_RIGHT: b = '{KIND_FORCE, {2'b00, force_table(sel)}};
      OP_ROLL_LEFT:  b = '{KIND_FORCE, 17'd0 - {2'b00, force_table(sel)}};
      OP_CLUTCH:     b = '{KIND_GAIN, {1'b0, gain_table(sel)}};
      default:       b = '{KIND_FORCE, ZERO_LEVEL};
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/wfcd_front.sv -----
// Front end: accepts polls, scales the analog level and classifies the command code.
`default_nettype none

module wfcd_front import wfcd_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire logic [31:0]   s_tdata,   // [9:0] analog_level, [17:10] command_high_byte,
                                        // [25:18] command_low_byte, [31:26] zero
  input  wire queue_status_t queue_status,
  output logic               push,
  output entry_t             push_entry
);

  logic [9:0]  analog_level;
  logic [7:0]  command_high_byte;
  logic [7:0]  command_low_byte;
  logic [7:0]  code;
  logic [7:0]  code_class;
  logic [7:0]  previous_code;
  logic [17:0] product;
  logic [7:0]  quot_low;
  logic [17:0] rem_wide;
  logic [10:0] rem;
  logic [7:0]  scaled;
  op_t         op;

  assign analog_level      = s_tdata[9:0];
  assign command_high_byte = s_tdata[17:10];
  assign command_low_byte  = s_tdata[25:18];

  assign s_tready = !queue_status.full;
  assign push     = s_tvalid && s_tready;

  // Scale level*255/1023: take the quotient by 1024, then correct by one
  assign product  = {analog_level, 8'b0} - 18'(analog_level);
  assign quot_low = product[17:10];
  assign rem_wide = product - {quot_low, 10'b0} + 18'(quot_low);
  assign rem      = rem_wide[10:0];
  assign scaled   = quot_low + 8'(rem >= 11'd1023);

  // Build the command code and its class
  assign code       = {command_high_byte[1:0], command_low_byte[7:2]};
  assign code_class = code & CLASS_MASK;

  // Pick the command sequence, fixed codes before classes
  always_comb begin
    op = OP_NONE;
    if (code != previous_code) begin
      if (code == CODE_RESET_ALL || code == CODE_FULL_ON) begin
        op = OP_FORCE_GAIN_CENTER;
      end else if (code == CODE_CENTER_A || code == CODE_CENTER_B) begin
        op = OP_CENTER_FORCE_GAIN;
      end else if (code == CODE_ALL_OFF) begin
        op = OP_ALL_OFF;
      end else if (code == CODE_FORCE_OFF) begin
        op = OP_FORCE_GAIN;
      end else if (code_class == CLASS_ROLL_RIGHT) begin
        op = OP_ROLL_RIGHT;
      end else if (code_class == CLASS_ROLL_LEFT) begin
        op = OP_ROLL_LEFT;
      end else if (code_class == CLASS_CLUTCH) begin
        op = OP_CLUTCH;
      end else if (code_class == CLASS_CENTER) begin
        op = OP_CENTER_FORCE_GAIN;
      end
    end
  end

  assign push_entry.switch_bits = ~scaled;
  assign push_entry.op          = op;
  assign push_entry.step_sel    = {code[5], code[6], code[7]};

  // Keep the code of the last accepted poll
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_code <= '0;
    end else if (push) begin
      previous_code <= code;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/wfcd_queue.sv -----
// Short queue of classified polls between the front and back ends.
`default_nettype none

module wfcd_queue import wfcd_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire entry_t  push_entry,
  input  wire logic    pop,
  output entry_t       head,
  output queue_status_t status
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t        slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign status.full  = (count == CW'(DEPTH));
  assign status.empty = (count == '0);
  assign head         = slots[rd_ptr];

  // Store pushed entries
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Advance pointers and track fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/wfcd_back.sv -----
// Back end: expands each queued poll into its result beats behind an output register.
`default_nettype none

module wfcd_back import wfcd_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire entry_t        head,
  input  wire queue_status_t queue_status,
  output logic               pop,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output logic [31:0]        m_tdata,   // [7:0] switch_bits, [24:8] level, [31:25] zero
  output logic [1:0]         m_tuser,   // [1:0] kind
  output logic               m_tlast
);

  logic [1:0]  step;
  logic [1:0]  step_next;
  logic        load;
  logic        beat_last;
  logic [1:0]  beat_kind;
  logic [7:0]  beat_switch;
  logic [16:0] beat_level;
  beat_t       cmd;

  assign load      = !queue_status.empty && (!m_tvalid || m_tready);
  assign beat_last = (step == op_len(head.op));
  assign pop       = load && beat_last;
  assign cmd       = cmd_at(head.op, step - 2'd1, head.step_sel);

  // Switch beat first, then the command beats
  always_comb begin
    if (step == 2'd0) begin
      beat_kind   = KIND_SWITCH;
      beat_switch = head.switch_bits;
      beat_level  = ZERO_LEVEL;
    end else begin
      beat_kind   = cmd.kind;
      beat_switch = 8'd0;
      beat_level  = cmd.level;
    end
  end

  assign step_next = !load ? step : (beat_last ? 2'd0 : step + 2'd1);

  // Advance the beat counter
  always_ff @(posedge clk) begin
    if (rst) begin
      step     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      step <= step_next;
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Hold the output beat until taken
  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {7'd0, beat_level, beat_switch};
      m_tuser <= beat_kind;
      m_tlast <= beat_last;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/wheel_force_command_decoder_core.sv -----
// Top level of the wheel force command decoder: front end, queue and back end.
// The switch beat of a poll passes through a queue slot and then the output register.
// Each poll gives one switch beat and then n = 0..3 command beats at the output,
//   sent by the back end's single output register one beat per cycle while m_tready allows.
// The input accepts a poll every cycle while the queue has room.
// Reset (rst, synchronous, active high) clears the kept code to zero, the queue and the output.
`default_nettype none

module wheel_force_command_decoder_core import wfcd_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [9:0] analog_level, [17:10] command_high_byte,
                                      // [25:18] command_low_byte, [31:26] zero
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // [7:0] switch_bits, [24:8] level, [31:25] zero
  output logic [1:0]       m_tuser,   // [1:0] kind
  output logic             m_tlast
);

  logic          push;
  logic          pop;
  entry_t        push_entry;
  entry_t        head;
  queue_status_t queue_status;

  wfcd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .queue_status (queue_status),
    .push         (push),
    .push_entry   (push_entry)
  );

  wfcd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .status     (queue_status)
  );

  wfcd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .queue_status (queue_status),
    .pop          (pop),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tuser      (m_tuser),
    .m_tlast      (m_tlast)
  );

  // The queue is never full and empty at once
  a_queue_status: assert property (@(posedge clk) disable iff (rst)
    !(queue_status.full && queue_status.empty))
    else $error("queue reports full and empty together");

  // A switch beat carries no level, a command beat no switch bits
  a_beat_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tuser == KIND_SWITCH) ? (m_tdata[24:8] == '0)
                                           : (m_tdata[7:0] == '0)))
    else $error("result beat carries fields of the wrong kind");

  // After a poll's final beat is taken, the next beat opens a new poll
  a_poll_start: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> (!m_tvalid || m_tuser == KIND_SWITCH))
    else $error("poll did not start with a switch beat");

  // Command beats of a poll follow without a gap
  a_poll_continue: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=> (m_tvalid && m_tuser != KIND_SWITCH))
    else $error("poll beats broken or switch beat repeated");

  // Output is empty right after reset
  a_reset_idle: assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("output valid right after reset");

endmodule

`default_nettype wire
